// File: rtl/core/ebdd_pkg.sv
// Shared types, codes and helpers of the encoder balanced differential drive unit.
package ebdd_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int BAL_W       = COUNT_WIDTH + 11;
	localparam int PROD_W      = COUNT_WIDTH + 15;
	localparam int DIST_W      = 23;

	localparam logic [7:0]        DUTY_MAX  = 8'd255;
	localparam logic [7:0]        GAIN_RESET = 8'd20;
	localparam logic [15:0]       DPT_RESET = 16'd256;
	localparam logic [DIST_W-1:0] DIST_MAX  = 23'd8388607;

	localparam logic [1:0] FUNC_CMD   = 2'd0;
	localparam logic [1:0] FUNC_LEFT  = 2'd1;
	localparam logic [1:0] FUNC_RIGHT = 2'd2;

	localparam logic [2:0] DIR_STOP = 3'd0;
	localparam logic [2:0] DIR_FWD  = 3'd1;
	localparam logic [2:0] DIR_BACK = 3'd2;
	localparam logic [2:0] DIR_ROTL = 3'd3;
	localparam logic [2:0] DIR_ROTR = 3'd4;

	localparam logic REG_GAIN = 1'b0;
	localparam logic REG_DPT  = 1'b1;

	typedef enum logic [4:0] {
		MODE_STOP = 5'b00001,
		MODE_FWD  = 5'b00010,
		MODE_BACK = 5'b00100,
		MODE_ROTL = 5'b01000,
		MODE_ROTR = 5'b10000
	} mode_t;

	typedef struct packed {
		logic [COUNT_WIDTH-1:0] left_count;
		logic [COUNT_WIDTH-1:0] right_count;
		logic [7:0]             base_speed;
		mode_t                  mode;
		logic [7:0]             left_duty;
		logic [7:0]             right_duty;
		logic                   left_dir;
		logic                   right_dir;
	} state_t;

	localparam state_t STATE_RESET = '{
		left_count:  '0,
		right_count: '0,
		base_speed:  8'd0,
		mode:        MODE_STOP,
		left_duty:   DUTY_MAX,
		right_duty:  DUTY_MAX,
		left_dir:    1'b1,
		right_dir:   1'b1
	};

	function automatic logic [7:0] clamp_duty(input logic signed [BAL_W-1:0] v);
		logic [7:0] r;
		if (v < 0) begin
			r = 8'd0;
		end else if (v > $signed(BAL_W'(DUTY_MAX))) begin
			r = DUTY_MAX;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

endpackage

// File: rtl/core/ebdd_step.sv
// Next-state and result logic for one command or encoder tick.
module ebdd_step (
	input  ebdd_pkg::state_t                  cur,
	input  logic [1:0]                        func,
	input  logic [2:0]                        direction,
	input  logic [7:0]                        speed,
	input  logic [7:0]                        gain,
	input  logic [15:0]                       dpt,
	output ebdd_pkg::state_t                  nxt,
	output logic [ebdd_pkg::DIST_W-1:0]       distance
);

	localparam int CW = ebdd_pkg::COUNT_WIDTH;

	logic [CW-1:0]                    lc_tick;
	logic [CW-1:0]                    rc_tick;
	logic [CW-1:0]                    lc_new;
	logic [CW-1:0]                    rc_new;
	logic signed [CW:0]               diff;
	logic signed [ebdd_pkg::BAL_W-1:0] bal;
	logic signed [ebdd_pkg::BAL_W-1:0] base_ext;
	logic [7:0]                       duty_lo;
	logic [7:0]                       duty_hi;
	logic [7:0]                       inv;
	logic signed [CW:0]               sum;
	logic signed [CW:0]               half;
	logic [ebdd_pkg::PROD_W-1:0]      prod;
	logic [63:0]                      scaled;

	always_comb begin
		unique case (cur.mode)
			ebdd_pkg::MODE_FWD: begin
				lc_tick = cur.left_count + CW'(1);
				rc_tick = cur.right_count + CW'(1);
			end
			ebdd_pkg::MODE_BACK: begin
				lc_tick = cur.left_count - CW'(1);
				rc_tick = cur.right_count - CW'(1);
			end
			default: begin
				lc_tick = cur.left_count;
				rc_tick = cur.right_count;
			end
		endcase
		lc_new = (func == ebdd_pkg::FUNC_LEFT) ? lc_tick : cur.left_count;
		rc_new = (func == ebdd_pkg::FUNC_RIGHT) ? rc_tick : cur.right_count;
	end

	always_comb begin
		diff     = $signed({lc_new[CW-1], lc_new}) - $signed({rc_new[CW-1], rc_new});
		bal      = ebdd_pkg::BAL_W'(diff) * $signed({{(ebdd_pkg::BAL_W-8){1'b0}}, gain});
		base_ext = $signed({{(ebdd_pkg::BAL_W-8){1'b0}}, cur.base_speed});
		duty_lo  = ebdd_pkg::clamp_duty(base_ext - bal);
		duty_hi  = ebdd_pkg::clamp_duty(base_ext + bal);
		inv      = ebdd_pkg::DUTY_MAX - speed;
	end

	always_comb begin
		nxt = cur;
		unique case (func)
			ebdd_pkg::FUNC_CMD: begin
				unique case (direction)
					ebdd_pkg::DIR_STOP: begin
						nxt = ebdd_pkg::STATE_RESET;
					end
					ebdd_pkg::DIR_FWD: begin
						nxt.left_duty  = inv;
						nxt.right_duty = inv;
						nxt.left_dir   = 1'b1;
						nxt.right_dir  = 1'b1;
						nxt.mode       = ebdd_pkg::MODE_FWD;
						nxt.base_speed = speed;
					end
					ebdd_pkg::DIR_BACK: begin
						nxt.left_duty  = speed;
						nxt.right_duty = speed;
						nxt.left_dir   = 1'b0;
						nxt.right_dir  = 1'b0;
						nxt.mode       = ebdd_pkg::MODE_BACK;
						nxt.base_speed = speed;
					end
					ebdd_pkg::DIR_ROTL: begin
						nxt.left_duty  = speed;
						nxt.right_duty = inv;
						nxt.left_dir   = 1'b0;
						nxt.right_dir  = 1'b1;
						nxt.mode       = ebdd_pkg::MODE_ROTL;
						nxt.base_speed = speed;
					end
					ebdd_pkg::DIR_ROTR: begin
						nxt.left_duty  = inv;
						nxt.right_duty = speed;
						nxt.left_dir   = 1'b1;
						nxt.right_dir  = 1'b0;
						nxt.mode       = ebdd_pkg::MODE_ROTR;
						nxt.base_speed = speed;
					end
					default: begin
						nxt = cur;
					end
				endcase
			end
			ebdd_pkg::FUNC_LEFT, ebdd_pkg::FUNC_RIGHT: begin
				nxt.left_count  = lc_new;
				nxt.right_count = rc_new;
				if (cur.mode == ebdd_pkg::MODE_FWD) begin
					nxt.left_duty  = ebdd_pkg::DUTY_MAX - duty_lo;
					nxt.right_duty = ebdd_pkg::DUTY_MAX - duty_hi;
				end else if (cur.mode == ebdd_pkg::MODE_BACK) begin
					nxt.left_duty  = duty_hi;
					nxt.right_duty = duty_lo;
				end
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

	// distance from the counts after this item
	always_comb begin
		sum    = $signed({nxt.left_count[CW-1], nxt.left_count})
		       + $signed({nxt.right_count[CW-1], nxt.right_count});
		half   = (sum + $signed({{CW{1'b0}}, sum[CW]})) >>> 1;
		prod   = ebdd_pkg::PROD_W'(half[CW-2:0]) * ebdd_pkg::PROD_W'(dpt);
		scaled = 64'(prod >> 8);
		if (half[CW] || half == '0) begin
			distance = '0;
		end else if (scaled > 64'(ebdd_pkg::DIST_MAX)) begin
			distance = ebdd_pkg::DIST_MAX;
		end else begin
			distance = scaled[ebdd_pkg::DIST_W-1:0];
		end
	end

endmodule

// File: rtl/core/encoder_balanced_differential_drive_unit.sv
// Top level of the encoder balanced differential drive unit.
// Each accepted transfer (a drive command or a left/right encoder tick) yields exactly one
// result transfer with both PWM duties, both direction pins and the travelled distance,
// all taken after the item has been applied. One item is accepted per clock cycle while the
// result output is not stalled: an input register feeds a single pass of update logic (one
// 8x17 balance multiply and one 15x16 distance multiply) into the state and result
// registers, so each result is valid once its item has passed the input register and then
// the result register. Registers: correction_gain at byte address 0, distance_per_tick
// at byte address 4; write them only while no transfer is in flight.
module encoder_balanced_differential_drive_unit (
	input  logic        clk,
	input  logic        arst_n,
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input items
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // direction[2:0], speed[10:3], zero[15:11]
	input  logic [1:0]  s_axis_tuser,   // func[1:0]
	// results
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata    // left_duty[7:0], right_duty[15:8], left_dir[16],
	                                    // right_dir[17], distance[40:18], zero[47:41]
);

	logic [7:0]                    gain_q;
	logic [15:0]                   dpt_q;
	logic                          valid_s1;
	logic [1:0]                    func_s1;
	logic [2:0]                    direction_s1;
	logic [7:0]                    speed_s1;
	ebdd_pkg::state_t              state_q;
	ebdd_pkg::state_t              state_nxt;
	logic [ebdd_pkg::DIST_W-1:0]   distance_nxt;
	logic                          out_valid_q;
	logic [47:0]                   out_data_q;
	logic                          advance;
	logic                          take_in;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= ebdd_pkg::GAIN_RESET;
			dpt_q  <= ebdd_pkg::DPT_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				ebdd_pkg::REG_GAIN: gain_q <= pwdata[7:0];
				ebdd_pkg::REG_DPT:  dpt_q  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			ebdd_pkg::REG_GAIN: prdata = {24'd0, gain_q};
			ebdd_pkg::REG_DPT:  prdata = {16'd0, dpt_q};
			default:            prdata = 32'd0;
		endcase
	end

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign take_in       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			func_s1      <= s_axis_tuser;
			direction_s1 <= s_axis_tdata[2:0];
			speed_s1     <= s_axis_tdata[10:3];
		end
	end

	ebdd_step u_step (
		.cur       (state_q),
		.func      (func_s1),
		.direction (direction_s1),
		.speed     (speed_s1),
		.gain      (gain_q),
		.dpt       (dpt_q),
		.nxt       (state_nxt),
		.distance  (distance_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ebdd_pkg::STATE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {7'd0, distance_nxt, state_nxt.right_dir, state_nxt.left_dir,
				state_nxt.right_duty, state_nxt.left_duty};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// File: tb/sv/tb_encoder_balanced_differential_drive_unit.sv
// Self-checking testbench of the encoder balanced differential drive unit.
module tb_encoder_balanced_differential_drive_unit;

	localparam int         CW          = ebdd_pkg::COUNT_WIDTH;
	localparam logic [1:0] FUNC_NONE  = 2'd3;
	localparam logic [2:0] DIR_BAD_A  = 3'd5;
	localparam logic [2:0] DIR_BAD_B  = 3'd6;
	localparam logic [2:0] DIR_BAD_C  = 3'd7;
	localparam int         HOLD_CYCLES = 300;
	localparam int         IDLE_LIMIT  = 4000;
	localparam int         DRAIN_CYCLES = 20;
	localparam int         PHASES      = 7;
	localparam int         PHASE_ITEMS = 200;

	typedef struct packed {
		logic [7:0]                  left_duty;
		logic [7:0]                  right_duty;
		logic                        left_dir;
		logic                        right_dir;
		logic [ebdd_pkg::DIST_W-1:0] distance;
	} drive_out_t;

	typedef struct packed {
		logic [1:0] func;
		logic [2:0] dir;
		logic [7:0] speed;
		logic       typed;
		drive_out_t want;
	} stim_row_t;

	localparam drive_out_t IDLE_OUT = '{ebdd_pkg::DUTY_MAX, ebdd_pkg::DUTY_MAX, 1'b1, 1'b1,
		'0};
	localparam drive_out_t FULL_FWD = '{8'd0, 8'd0, 1'b1, 1'b1, '0};
	localparam drive_out_t NO_OUT   = '0;

	localparam stim_row_t DIRECTED [26] = '{
		'{ebdd_pkg::FUNC_LEFT,  ebdd_pkg::DIR_STOP, 8'd0,   1'b1, IDLE_OUT},
		'{FUNC_NONE,            DIR_BAD_C,          8'd255, 1'b1, IDLE_OUT},
		'{ebdd_pkg::FUNC_RIGHT, DIR_BAD_C,          8'd255, 1'b1, IDLE_OUT},
		'{ebdd_pkg::FUNC_CMD,   ebdd_pkg::DIR_FWD,  8'd255, 1'b1, FULL_FWD},
		'{ebdd_pkg::FUNC_LEFT,  ebdd_pkg::DIR_STOP, 8'd0,   1'b0, NO_OUT},
		'{ebdd_pkg::FUNC_LEFT,  DIR_BAD_C,          8'd255, 1'b0, NO_OUT},
		'{ebdd_pkg::FUNC_LEFT,  ebdd_pkg::DIR_STOP, 8'd0,   1'b0, NO_OUT},
		'{ebdd_pkg::FUNC_RIGHT, ebdd_pkg::DIR_STOP, 8'd0,   1'b0, NO_OUT},
		'{ebdd_pkg::FUNC_CMD,   DIR_BAD_A,          8'd77,  1'b0, NO_OUT},
		'{ebdd_pkg::FUNC_CMD,   DIR_BAD_B,          8'd0,   1'b0, NO_OUT},
		'{ebdd_pkg::FUNC_CMD,   DIR_BAD_C,          8'd255, 1'b0, NO_OUT},
		'{ebdd_pkg::FUNC_CMD,   ebdd_pkg::DIR_ROTL, 8'd0,   1'b0, NO_OUT},
		'{ebdd_pkg::FUNC_RIGHT, ebdd_pkg::DIR_STOP, 8'd0,   1'b0, NO_OUT},
		'{ebdd_pkg::FUNC_CMD,   ebdd_pkg::DIR_ROTR, 8'd255, 1'b0, NO_OUT},
		'{ebdd_pkg::FUNC_LEFT,  ebdd_pkg::DIR_STOP, 8'd0,   1'b0, NO_OUT},
		'{ebdd_pkg::FUNC_CMD,   ebdd_pkg::DIR_BACK, 8'd255, 1'b0, NO_OUT},
		'{ebdd_pkg::FUNC_LEFT,  ebdd_pkg::DIR_STOP, 8'd0,   1'b0, NO_OUT},
		'{ebdd_pkg::FUNC_RIGHT, ebdd_pkg::DIR_STOP, 8'd0,   1'b0, NO_OUT},
		'{ebdd_pkg::FUNC_RIGHT, ebdd_pkg::DIR_STOP, 8'd0,   1'b0, NO_OUT},
		'{ebdd_pkg::FUNC_CMD,   ebdd_pkg::DIR_STOP, 8'd200, 1'b1, IDLE_OUT},
		'{ebdd_pkg::FUNC_CMD,   ebdd_pkg::DIR_BACK, 8'd128, 1'b0, NO_OUT},
		'{ebdd_pkg::FUNC_RIGHT, ebdd_pkg::DIR_STOP, 8'd0,   1'b0, NO_OUT},
		'{ebdd_pkg::FUNC_LEFT,  ebdd_pkg::DIR_STOP, 8'd0,   1'b0, NO_OUT},
		'{ebdd_pkg::FUNC_CMD,   ebdd_pkg::DIR_FWD,  8'd0,   1'b0, NO_OUT},
		'{ebdd_pkg::FUNC_RIGHT, ebdd_pkg::DIR_STOP, 8'd0,   1'b0, NO_OUT},
		'{ebdd_pkg::FUNC_CMD,   ebdd_pkg::DIR_STOP, 8'd0,   1'b1, IDLE_OUT}
	};

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;   // direction[2:0], speed[10:3], zero[15:11]
	logic [1:0]  s_axis_tuser;   // func[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;   // left_duty[7:0], right_duty[15:8], left_dir[16],
	                             // right_dir[17], distance[40:18], zero[47:41]

	// drive state tracked alongside the block
	logic [CW-1:0]          left_ticks;
	logic [CW-1:0]          right_ticks;
	logic [7:0]             base_speed;
	ebdd_pkg::mode_t        motion;
	logic [7:0]             left_duty;
	logic [7:0]             right_duty;
	logic                   left_pin;
	logic                   right_pin;
	logic [7:0]             gain_cfg;
	logic [15:0]            dpt_cfg;

	drive_out_t due_drive [$];
	int  mismatches;
	int  live_items;
	int  results_seen;
	int  reg_writes;
	int  haul_ticks;
	int  idle_cycles;
	bit  tx_steady;
	bit  rx_steady;
	bit  hold_req;
	bit  hold_done;

	encoder_balanced_differential_drive_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] sat_duty(input int v);
		if (v < 0) begin
			return 8'd0;
		end
		if (v > int'(ebdd_pkg::DUTY_MAX)) begin
			return ebdd_pkg::DUTY_MAX;
		end
		return v[7:0];
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75) begin
			return $urandom_range(1, 3);
		end else if (r < 95) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 80);
	endfunction

	function automatic logic [7:0] pick_speed();
		int r;
		r = $urandom_range(0, 99);
		if (r < 12) begin
			return 8'd0;
		end else if (r < 24) begin
			return ebdd_pkg::DUTY_MAX;
		end
		return 8'($urandom_range(0, 255));
	endfunction

	// apply one item to the tracked state and return the outputs it leaves
	function automatic drive_out_t advance_drive(input logic [1:0] func,
			input logic [2:0] dir, input logic [7:0] spd);
		drive_out_t o;
		logic [CW-1:0] step;
		int bal;
		int half;
		longint travel;
		if (func == ebdd_pkg::FUNC_CMD) begin
			case (dir)
				ebdd_pkg::DIR_STOP: begin
					left_duty = ebdd_pkg::DUTY_MAX; right_duty = ebdd_pkg::DUTY_MAX;
					left_pin = 1'b1; right_pin = 1'b1;
					motion = ebdd_pkg::MODE_STOP; base_speed = 8'd0;
					left_ticks = '0; right_ticks = '0;
				end
				ebdd_pkg::DIR_FWD: begin
					left_duty = ebdd_pkg::DUTY_MAX - spd;
					right_duty = ebdd_pkg::DUTY_MAX - spd;
					left_pin = 1'b1; right_pin = 1'b1;
					motion = ebdd_pkg::MODE_FWD; base_speed = spd;
				end
				ebdd_pkg::DIR_BACK: begin
					left_duty = spd; right_duty = spd;
					left_pin = 1'b0; right_pin = 1'b0;
					motion = ebdd_pkg::MODE_BACK; base_speed = spd;
				end
				ebdd_pkg::DIR_ROTL: begin
					left_duty = spd; right_duty = ebdd_pkg::DUTY_MAX - spd;
					left_pin = 1'b0; right_pin = 1'b1;
					motion = ebdd_pkg::MODE_ROTL; base_speed = spd;
				end
				ebdd_pkg::DIR_ROTR: begin
					left_duty = ebdd_pkg::DUTY_MAX - spd; right_duty = spd;
					left_pin = 1'b1; right_pin = 1'b0;
					motion = ebdd_pkg::MODE_ROTR; base_speed = spd;
				end
				default: begin
				end
			endcase
		end else if ((func == ebdd_pkg::FUNC_LEFT || func == ebdd_pkg::FUNC_RIGHT) &&
				(motion == ebdd_pkg::MODE_FWD || motion == ebdd_pkg::MODE_BACK)) begin
			step = (motion == ebdd_pkg::MODE_FWD) ? CW'(1) : '1;
			if (func == ebdd_pkg::FUNC_LEFT) begin
				left_ticks = left_ticks + step;
			end else begin
				right_ticks = right_ticks + step;
			end
			bal = (int'($signed(left_ticks)) - int'($signed(right_ticks))) * int'(gain_cfg);
			if (motion == ebdd_pkg::MODE_FWD) begin
				left_duty  = ebdd_pkg::DUTY_MAX - sat_duty(int'(base_speed) - bal);
				right_duty = ebdd_pkg::DUTY_MAX - sat_duty(int'(base_speed) + bal);
			end else begin
				left_duty  = sat_duty(int'(base_speed) + bal);
				right_duty = sat_duty(int'(base_speed) - bal);
			end
		end
		half = (int'($signed(left_ticks)) + int'($signed(right_ticks))) / 2;
		if (half <= 0) begin
			travel = 0;
		end else begin
			travel = (longint'(half) * longint'(dpt_cfg)) >>> 8;
			if (travel > longint'(ebdd_pkg::DIST_MAX)) begin
				travel = longint'(ebdd_pkg::DIST_MAX);
			end
		end
		o.left_duty  = left_duty;
		o.right_duty = right_duty;
		o.left_dir   = left_pin;
		o.right_dir  = right_pin;
		o.distance   = travel[ebdd_pkg::DIST_W-1:0];
		return o;
	endfunction

	task automatic apb_xfer(input logic wr, input logic sel, input logic [31:0] wdat,
			output logic [31:0] rdat);
		@(negedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= wr; paddr <= {sel, 2'b00}; pwdata <= wdat;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdat = prdata;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0;
	endtask

	task automatic check_reg(input logic sel, input logic [31:0] want);
		logic [31:0] got;
		apb_xfer(1'b0, sel, 32'd0, got);
		if (got !== want) begin
			$display("%0t: register %0d read expected %0d actual %0d", $time, sel, want, got);
			mismatches++;
		end
	endtask

	task automatic set_regs(input logic [7:0] gain, input logic [15:0] dpt);
		logic [31:0] unused;
		apb_xfer(1'b1, ebdd_pkg::REG_GAIN, {24'd0, gain}, unused);
		gain_cfg = gain;
		apb_xfer(1'b1, ebdd_pkg::REG_DPT, {16'd0, dpt}, unused);
		dpt_cfg = dpt;
		reg_writes += 2;
		check_reg(ebdd_pkg::REG_GAIN, {24'd0, gain});
		check_reg(ebdd_pkg::REG_DPT, {16'd0, dpt});
	endtask

	task automatic send_item(input logic [1:0] func, input logic [2:0] dir,
			input logic [7:0] spd, input logic typed, input drive_out_t want);
		drive_out_t got;
		int g;
		g = (!tx_steady && $urandom_range(0, 99) < 35) ? pick_gap() : 0;
		@(negedge clk);
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {5'd0, spd, dir};
		s_axis_tuser  <= func;
		do @(posedge clk); while (!s_axis_tready);
		got = advance_drive(func, dir, spd);
		due_drive.push_back(typed ? want : got);
		if (func != FUNC_NONE && !(func == ebdd_pkg::FUNC_CMD && dir > ebdd_pkg::DIR_ROTR)) begin
			live_items++;
		end
	endtask

	task automatic send_tick(input logic left);
		send_item(left ? ebdd_pkg::FUNC_LEFT : ebdd_pkg::FUNC_RIGHT, 3'($urandom_range(0, 7)),
			8'($urandom_range(0, 255)), 1'b0, NO_OUT);
	endtask

	task automatic send_cmd(input logic [2:0] dir, input logic [7:0] spd);
		send_item(ebdd_pkg::FUNC_CMD, dir, spd, 1'b0, NO_OUT);
	endtask

	task automatic tx_drop();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	task automatic drain();
		tx_drop();
		wait (due_drive.size() == 0);
		repeat (4) @(posedge clk);
	endtask

	// one straight run with a random lean to one wheel, or a short burst of the rest
	task automatic drive_sequence();
		int r;
		int n;
		int lean;
		r = $urandom_range(0, 99);
		tx_steady = ($urandom_range(0, 9) == 0);
		rx_steady = ($urandom_range(0, 9) == 0);
		if (r < 80) begin
			send_cmd($urandom_range(0, 1) ? ebdd_pkg::DIR_FWD : ebdd_pkg::DIR_BACK,
				pick_speed());
			n = $urandom_range(1, 40);
			lean = $urandom_range(0, 100);
			repeat (n) send_tick($urandom_range(0, 99) < lean);
		end else if (r < 92) begin
			case ($urandom_range(0, 2))
				0: send_cmd(ebdd_pkg::DIR_ROTL, pick_speed());
				1: send_cmd(ebdd_pkg::DIR_ROTR, pick_speed());
				default: send_cmd(ebdd_pkg::DIR_STOP, pick_speed());
			endcase
			repeat ($urandom_range(0, 4)) send_tick($urandom_range(0, 1));
		end else begin
			if ($urandom_range(0, 1)) begin
				send_item(FUNC_NONE, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
					1'b0, NO_OUT);
			end else begin
				send_cmd(3'($urandom_range(DIR_BAD_A, DIR_BAD_C)), pick_speed());
			end
			send_tick($urandom_range(0, 1));
		end
	endtask

	always @(posedge clk) begin : result_check
		drive_out_t want;
		drive_out_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = drive_out_t'({m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[16],
				m_axis_tdata[17], m_axis_tdata[40:18]});
			results_seen++;
			if (due_drive.size() == 0) begin
				$display("%0t: unexpected transfer actual %h", $time, got);
				mismatches++;
			end else begin
				want = due_drive.pop_front();
				if (got.left_duty !== want.left_duty) begin
					$display("%0t: left_duty expected %0d actual %0d", $time,
						want.left_duty, got.left_duty);
					mismatches++;
				end
				if (got.right_duty !== want.right_duty) begin
					$display("%0t: right_duty expected %0d actual %0d", $time,
						want.right_duty, got.right_duty);
					mismatches++;
				end
				if (got.left_dir !== want.left_dir) begin
					$display("%0t: left_dir expected %0d actual %0d", $time,
						want.left_dir, got.left_dir);
					mismatches++;
				end
				if (got.right_dir !== want.right_dir) begin
					$display("%0t: right_dir expected %0d actual %0d", $time,
						want.right_dir, got.right_dir);
					mismatches++;
				end
				if (got.distance !== want.distance) begin
					$display("%0t: distance expected %0d actual %0d", $time,
						want.distance, got.distance);
					mismatches++;
				end
			end
		end
	end

	initial begin : result_sink
		int stall;
		stall = 0;
		m_axis_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_done = 1'b1;
				stall = HOLD_CYCLES;
			end else if (stall == 0 && !rx_steady && $urandom_range(0, 99) < 30) begin
				stall = pick_gap();
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				stall--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) ||
				(m_axis_tvalid && m_axis_tready) || psel) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles == IDLE_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [7:0]  gains [PHASES];
		logic [15:0] dpts  [PHASES];
		int target;
		int n;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = ebdd_pkg::FUNC_CMD;
		mismatches = 0; live_items = 0; results_seen = 0; reg_writes = 0; haul_ticks = 0;
		tx_steady = 1'b0; rx_steady = 1'b0; hold_req = 1'b0; hold_done = 1'b0;
		left_ticks = '0; right_ticks = '0; base_speed = 8'd0;
		motion = ebdd_pkg::MODE_STOP; left_duty = ebdd_pkg::DUTY_MAX;
		right_duty = ebdd_pkg::DUTY_MAX;
		left_pin = 1'b1; right_pin = 1'b1;
		gain_cfg = ebdd_pkg::GAIN_RESET; dpt_cfg = ebdd_pkg::DPT_RESET;
		gains = '{8'd0, 8'd255, ebdd_pkg::GAIN_RESET, 8'd1, 8'd128, 8'd0, 8'd0};
		dpts  = '{16'd0, 16'hFFFF, ebdd_pkg::DPT_RESET, 16'd1, 16'd0, 16'd0, 16'd0};
		for (int p = 4; p < PHASES; p++) begin
			gains[p] = 8'($urandom_range(0, 255));
			dpts[p]  = 16'($urandom_range(0, 65535));
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		check_reg(ebdd_pkg::REG_GAIN, {24'd0, ebdd_pkg::GAIN_RESET});
		check_reg(ebdd_pkg::REG_DPT, {16'd0, ebdd_pkg::DPT_RESET});
		foreach (DIRECTED[i]) begin
			send_item(DIRECTED[i].func, DIRECTED[i].dir, DIRECTED[i].speed,
				DIRECTED[i].typed, DIRECTED[i].want);
		end
		drain();

		for (int p = 0; p < PHASES; p++) begin
			set_regs(gains[p], dpts[p]);
			if (p == 1) begin
				hold_req = 1'b1;
			end
			target = live_items + PHASE_ITEMS;
			while (live_items < target) begin
				drive_sequence();
			end
			drain();
		end

		// long forward haul: run the left count far ahead of the right
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		set_regs(8'd7, 16'hFFFF);
		send_cmd(ebdd_pkg::DIR_STOP, 8'd0);
		send_cmd(ebdd_pkg::DIR_FWD, pick_speed());
		n = $urandom_range(150, 200);
		repeat (n) send_tick(1'b1);
		haul_ticks = n;
		repeat (40) send_tick($urandom_range(0, 1));
		send_cmd(ebdd_pkg::DIR_BACK, pick_speed());
		repeat (40) send_tick($urandom_range(0, 1));
		send_cmd(ebdd_pkg::DIR_STOP, 8'd0);
		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d live items and %0d checked results over %0d register writes,",
			live_items, results_seen, reg_writes);
		$display("including a %0d-tick left-wheel forward haul; receiver hold-off %0s.",
			haul_ticks, hold_done ? "done" : "missed");
		if (mismatches == 0 && hold_done) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// File: encoder_balanced_differential_drive_unit.f
rtl/core/ebdd_pkg.sv
rtl/core/ebdd_step.sv
rtl/core/encoder_balanced_differential_drive_unit.sv
tb/sv/tb_encoder_balanced_differential_drive_unit.sv
